// ===== hdl/pic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_pkg
// Shared widths, register indexes, reset values and the control/status
// structs for the pulse interval capture block.
// ----------------------------------------------------------------------------
package pic_pkg;

   localparam int COUNTER_WIDTH_DEF = 16;

   localparam int CNT_W    = 16;
   localparam int WORD_W   = 32;
   localparam int RELOAD_W = 16;
   localparam int PRESC_W  = 17;
   localparam int TPU_W    = 8;
   localparam int BSIZE_W  = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_RELOAD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRESCALE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TPU      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BUF_EN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BUF_SIZE = 3'd5;

   localparam logic [RELOAD_W-1:0] RST_RELOAD   = 16'd65535;
   localparam logic [PRESC_W-1:0]  RST_PRESCALE = 17'd72;
   localparam logic [TPU_W-1:0]    RST_TPU      = 8'd72;
   localparam logic [WORD_W-1:0]   RST_WINDOW   = 32'd1000000;
   localparam logic                RST_BUF_EN   = 1'b1;
   localparam logic [BSIZE_W-1:0]  RST_BUF_SIZE = 16'd256;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 88;
   localparam int RSP_TUSER_W = 3;

   localparam logic OP_OVERFLOW = 1'b0;
   localparam logic OP_EDGE     = 1'b1;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic load;
      logic arm;
      logic ovf_upd;
      logic mul1;
      logic raw;
      logic mul2;
      logic div_step;
      logic commit;
   } pic_cmd_type;

   typedef struct packed {
      logic opcode;
      logic armed;
      logic finished;
      logic window_pass;
      logic out_free;
   } pic_stat_type;

endpackage

// ===== hdl/pic_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_ctrl
// Sequencer for the capture block: decodes each event and steps the
// datapath through raw count, scaling multiply, serial divide and write-out.
// ----------------------------------------------------------------------------
module pic_ctrl
   import pic_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  pic_stat_type stat,
   output pic_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_RAW    = 3'd2;
   localparam logic [2:0] S_MUL    = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_OVCHK  = 3'd5;
   localparam logic [2:0] S_WRITE  = 3'd6;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   logic [2:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.finished) begin
               state_in = S_IDLE;
            end else if (stat.opcode == OP_OVERFLOW) begin
               if (stat.armed) begin
                  cmd.ovf_upd = 1'b1;
                  state_in    = S_OVCHK;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (!stat.armed) begin
               cmd.arm  = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.mul1 = 1'b1;
               state_in = S_RAW;
            end
         end
         S_RAW: begin
            cmd.raw  = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul2 = 1'b1;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_WRITE;
            end
         end
         S_OVCHK: begin
            state_in = stat.window_pass ? S_WRITE : S_IDLE;
         end
         S_WRITE: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== hdl/pic_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_datapath
// Configuration registers, capture state, interval arithmetic with a
// radix-2 restoring divider, and the result register.
// ----------------------------------------------------------------------------
module pic_datapath
   import pic_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pic_cmd_type            cmd,
   output pic_stat_type           stat,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   localparam logic [WORD_W:0]   MASK_WIDE = (33'd1 << COUNTER_WIDTH) - 33'd1;
   localparam logic [WORD_W-1:0] CNT_MASK  = MASK_WIDE[WORD_W-1:0];

   // configuration
   logic [RELOAD_W-1:0] reload_ff;
   logic [PRESC_W-1:0]  presc_ff;
   logic [TPU_W-1:0]    tpu_ff;
   logic [WORD_W-1:0]   window_ff;
   logic                buf_en_ff;
   logic [BSIZE_W-1:0]  buf_size_ff;

   // capture state
   logic              armed_ff, finished_ff;
   logic [CNT_W-1:0]  last_ff, ovf_ff, start_ff, icount_ff;
   logic [WORD_W-1:0] elapsed_ff;

   // event latch
   logic             opcode_ff, pin_ff;
   logic [CNT_W-1:0] cap_ff, now_ff;

   // arithmetic
   logic [WORD_W-1:0]  prod1_ff, raw_ff, dvq_ff;
   logic [TPU_W-1:0]   rem_ff;
   logic [TPU_W:0]     trial;
   logic               trial_ge;
   logic [PRESC_W+WORD_W-1:0] prod2;
   logic [WORD_W-1:0]  cap32, last32, raw_in;

   // result register
   logic                   out_valid_ff;
   logic [RSP_TDATA_W-1:0] out_data_ff;
   logic [RSP_TUSER_W-1:0] out_user_ff;

   // window test
   logic [WORD_W-1:0] span;
   logic              window_pass;

   // commit decisions
   logic store, ends;
   logic [RSP_TDATA_W-1:0] data_in;
   logic [RSP_TUSER_W-1:0] user_in;

   always_comb begin
      if (elapsed_ff != '0) begin
         span = elapsed_ff - {16'd0, start_ff};
      end else begin
         span = {16'd0, now_ff} - {16'd0, start_ff};
      end
      window_pass = (span > window_ff);
   end

   assign stat.opcode      = opcode_ff;
   assign stat.armed       = armed_ff;
   assign stat.finished    = finished_ff;
   assign stat.window_pass = window_pass;
   assign stat.out_free    = !out_valid_ff || rsp_tready;

   assign cap32  = {16'd0, cap_ff};
   assign last32 = {16'd0, last_ff};

   always_comb begin
      if (ovf_ff != '0) begin
         raw_in = cap32 + prod1_ff - last32;
      end else begin
         raw_in = (cap32 - last32) & CNT_MASK;
      end
   end

   assign prod2    = (PRESC_W+WORD_W)'(raw_ff) * (PRESC_W+WORD_W)'(presc_ff);
   assign trial    = {rem_ff, dvq_ff[WORD_W-1]};
   assign trial_ge = (trial >= {1'b0, tpu_ff});

   always_comb begin
      store   = buf_en_ff && (icount_ff < buf_size_ff);
      ends    = (buf_en_ff && (icount_ff >= buf_size_ff)) || window_pass;
      data_in = '0;
      user_in = '0;
      if (opcode_ff == OP_OVERFLOW) begin
         user_in[2]     = 1'b1;
         data_in[80:65] = icount_ff;
      end else begin
         data_in[47:16] = dvq_ff;
         if (store) begin
            user_in[0]     = 1'b1;
            data_in[15:0]  = icount_ff;
         end
         if (ends) begin
            user_in[2]     = 1'b1;
            data_in[80:65] = icount_ff;
         end else begin
            user_in[1]     = 1'b1;
            data_in[48]    = pin_ff;
            data_in[64:49] = icount_ff;
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff   <= RST_RELOAD;
         presc_ff    <= RST_PRESCALE;
         tpu_ff      <= RST_TPU;
         window_ff   <= RST_WINDOW;
         buf_en_ff   <= RST_BUF_EN;
         buf_size_ff <= RST_BUF_SIZE;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_RELOAD:   reload_ff   <= csr_wdata[RELOAD_W-1:0];
            REG_PRESCALE: presc_ff    <= csr_wdata[PRESC_W-1:0];
            REG_TPU:      tpu_ff      <= csr_wdata[TPU_W-1:0];
            REG_WINDOW:   window_ff   <= csr_wdata[WORD_W-1:0];
            REG_BUF_EN:   buf_en_ff   <= csr_wdata[0];
            REG_BUF_SIZE: buf_size_ff <= csr_wdata[BSIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // capture state
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff    <= 1'b0;
         finished_ff <= 1'b0;
         last_ff     <= '0;
         ovf_ff      <= '0;
         start_ff    <= '0;
         icount_ff   <= '0;
         elapsed_ff  <= '0;
      end else begin
         if (cmd.arm) begin
            armed_ff   <= 1'b1;
            last_ff    <= cap_ff;
            start_ff   <= now_ff;
            ovf_ff     <= '0;
            elapsed_ff <= '0;
         end
         if (cmd.ovf_upd) begin
            ovf_ff     <= ovf_ff + 1'b1;
            elapsed_ff <= elapsed_ff + {16'd0, reload_ff};
         end
         if (cmd.commit) begin
            if (opcode_ff == OP_OVERFLOW || ends) begin
               finished_ff <= 1'b1;
            end else begin
               icount_ff <= icount_ff + 1'b1;
               last_ff   <= cap_ff;
               ovf_ff    <= '0;
            end
         end
      end
   end

   // event latch and arithmetic
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opcode_ff <= req_tuser;
         cap_ff    <= req_tdata[15:0];
         now_ff    <= req_tdata[31:16];
         pin_ff    <= req_tdata[32];
      end
      if (cmd.mul1) begin
         prod1_ff <= WORD_W'(reload_ff) * WORD_W'(ovf_ff);
      end
      if (cmd.raw) begin
         raw_ff <= raw_in;
      end
      if (cmd.mul2) begin
         dvq_ff <= prod2[WORD_W-1:0];
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvq_ff <= {dvq_ff[WORD_W-2:0], trial_ge};
         rem_ff <= trial_ge ? TPU_W'(trial - {1'b0, tpu_ff}) : trial[TPU_W-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_data_ff <= data_in;
         out_user_ff <= user_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

// ===== hdl/pulse_interval_capture.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_interval_capture
// Edge-to-edge interval meter for one capture channel. Bridges counter
// overflows with the reload value and converts intervals to microseconds.
// ----------------------------------------------------------------------------
// Sequence: a measuring edge passes decode, raw count, multiply, 32 divide
//   steps and write-out after acceptance; an ending overflow passes decode,
//   the window check and write-out; silent events end in decode or the check.
// Flow: one event at a time; the next event is accepted only once the last
//   one is done. The result register frees the next accept.
// Reset: synchronous; clears capture state and loads register defaults.
// ----------------------------------------------------------------------------
module pulse_interval_capture
   import pic_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // capture_value, counter_now, pin_level, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // opcode
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // store_index, interval_us, sample_level, sample_index, final_count, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // store_valid, sample_valid, done_res
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   pic_cmd_type  cmd;
   pic_stat_type stat;

   pic_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pic_datapath #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== bench/pulse_interval_capture_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_interval_capture_check
// Watches the register port and both streams of the interval meter. Tracks
// the capture state and the registers, works out the report each accepted
// event gives, and compares each report beat field by field, oldest first.
// ----------------------------------------------------------------------------
module pulse_interval_capture_check
   import pic_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [RSP_TUSER_W-1:0] rsp_tuser,
   output int                     mismatches,
   output int                     outstanding
);

   typedef struct {
      logic              store_valid;
      logic [CNT_W-1:0]  store_index;
      logic [WORD_W-1:0] interval_us;
      logic              sample_valid;
      logic              sample_level;
      logic [CNT_W-1:0]  sample_index;
      logic              done_res;
      logic [CNT_W-1:0]  final_count;
   } interval_report_t;

   logic [RELOAD_W-1:0] reload_val;
   logic [PRESC_W-1:0]  prescale;
   logic [TPU_W-1:0]    ticks_us;
   logic [WORD_W-1:0]   window;
   logic                buf_en;
   logic [BSIZE_W-1:0]  buf_size;

   logic                armed;
   logic                ended;
   logic [CNT_W-1:0]    last_cap;
   logic [CNT_W-1:0]    ovf_cnt;
   logic [WORD_W-1:0]   elapsed;
   logic [CNT_W-1:0]    start_cnt;
   logic [CNT_W-1:0]    taken;

   interval_report_t expected_reports[$];
   int errors = 0;

   function automatic bit window_passed(input logic [CNT_W-1:0] now);
      logic [WORD_W-1:0] span;
      span = (elapsed != 0) ? elapsed - WORD_W'(start_cnt)
                            : WORD_W'(now) - WORD_W'(start_cnt);
      return span > window;
   endfunction

   // Advance the capture state by one event; return 1 when it gives a report.
   function automatic bit measure_event(input logic op, input logic [CNT_W-1:0] cap,
                                        input logic [CNT_W-1:0] now, input logic level,
                                        output interval_report_t rep);
      logic [WORD_W-1:0] raw;
      logic [WORD_W-1:0] prod;
      rep = '{default: '0};
      if (ended)
         return 0;
      if (op == OP_OVERFLOW) begin
         if (!armed)
            return 0;
         ovf_cnt = ovf_cnt + 1'b1;
         elapsed = elapsed + WORD_W'(reload_val);
         if (window_passed(now)) begin
            ended           = 1'b1;
            rep.done_res    = 1'b1;
            rep.final_count = taken;
            return 1;
         end
         return 0;
      end
      if (!armed) begin
         last_cap  = cap;
         armed     = 1'b1;
         elapsed   = '0;
         start_cnt = now;
         ovf_cnt   = '0;
         return 0;
      end
      if (ovf_cnt != 0)
         raw = WORD_W'(cap) + WORD_W'(reload_val) * WORD_W'(ovf_cnt) - WORD_W'(last_cap);
      else
         raw = WORD_W'(CNT_W'(cap - last_cap));
      prod = raw * WORD_W'(prescale);
      rep.interval_us = (ticks_us != 0) ? prod / WORD_W'(ticks_us) : '1;
      if (buf_en && taken < buf_size) begin
         rep.store_valid = 1'b1;
         rep.store_index = taken;
      end
      if ((buf_en && taken >= buf_size) || window_passed(now)) begin
         ended           = 1'b1;
         rep.done_res    = 1'b1;
         rep.final_count = taken;
         return 1;
      end
      rep.sample_valid = 1'b1;
      rep.sample_level = level;
      rep.sample_index = taken;
      taken            = taken + 1'b1;
      last_cap         = cap;
      ovf_cnt          = '0;
      return 1;
   endfunction

   task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      interval_report_t got;
      interval_report_t want;
      if (reset) begin
         reload_val = RST_RELOAD;
         prescale   = RST_PRESCALE;
         ticks_us   = RST_TPU;
         window     = RST_WINDOW;
         buf_en     = RST_BUF_EN;
         buf_size   = RST_BUF_SIZE;
         armed      = 1'b0;
         ended      = 1'b0;
         last_cap   = '0;
         ovf_cnt    = '0;
         elapsed    = '0;
         start_cnt  = '0;
         taken      = '0;
         expected_reports.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_RELOAD:   reload_val = csr_wdata[RELOAD_W-1:0];
               REG_PRESCALE: prescale   = csr_wdata[PRESC_W-1:0];
               REG_TPU:      ticks_us   = csr_wdata[TPU_W-1:0];
               REG_WINDOW:   window     = csr_wdata[WORD_W-1:0];
               REG_BUF_EN:   buf_en     = csr_wdata[0];
               REG_BUF_SIZE: buf_size   = csr_wdata[BSIZE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.store_valid  = rsp_tuser[0];
            got.sample_valid = rsp_tuser[1];
            got.done_res     = rsp_tuser[2];
            got.store_index  = rsp_tdata[15:0];
            got.interval_us  = rsp_tdata[47:16];
            got.sample_level = rsp_tdata[48];
            got.sample_index = rsp_tdata[64:49];
            got.final_count  = rsp_tdata[80:65];
            if (expected_reports.size() == 0) begin
               $error("report beat with none expected");
               errors++;
            end else begin
               want = expected_reports.pop_front();
               check_field("store_valid", want.store_valid, got.store_valid);
               check_field("store_index", want.store_index, got.store_index);
               check_field("interval_us", want.interval_us, got.interval_us);
               check_field("sample_valid", want.sample_valid, got.sample_valid);
               check_field("sample_level", want.sample_level, got.sample_level);
               check_field("sample_index", want.sample_index, got.sample_index);
               check_field("done_res", want.done_res, got.done_res);
               check_field("final_count", want.final_count, got.final_count);
            end
         end
         if (req_tvalid && req_tready) begin
            if (measure_event(req_tuser, req_tdata[15:0], req_tdata[31:16], req_tdata[32],
                              want))
               expected_reports.push_back(want);
         end
      end
      outstanding <= expected_reports.size();
      mismatches  <= errors;
   end

endmodule

// ===== bench/pulse_interval_capture_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_interval_capture_tb
// Drives overflow and edge events into the interval meter: a directed pass
// over the field extremes, every register and the zero divisor, one long
// run of overflows bridged in a single interval, random phases under random
// register settings, and a closing phase that ends the capture. The checker
// instance judges every report beat.
// ----------------------------------------------------------------------------
module pulse_interval_capture_tb;
   import pic_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_EVENTS  = 230;
   localparam int LONG_RUN      = 100;

   typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_SPARSE} sink_mode_e;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   // capture_value, counter_now, pin_level, zero pad
   logic [REQ_TDATA_W-1:0] req_tdata;
   // opcode
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // store_index, interval_us, sample_level, sample_index, final_count, zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // store_valid, sample_valid, done_res
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   int         mismatches;
   int         outstanding;
   sink_mode_e sink_mode = SINK_OPEN;
   int         sink_left = 0;
   int         sink_tick = 0;

   always #2 clock = ~clock;

   pulse_interval_capture dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   pulse_interval_capture_check u_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Receiver: switch to a randomly chosen stall pattern when the current one runs out.
   always @(posedge clock) begin
      sink_tick <= sink_tick + 1;
      if (sink_left == 0) begin
         sink_mode <= sink_mode_e'($urandom_range(0, 3));
         sink_left <= $urandom_range(50, 300);
      end else begin
         sink_left <= sink_left - 1;
      end
      case (sink_mode)
         SINK_OPEN:     rsp_tready <= 1'b1;
         SINK_RANDOM:   rsp_tready <= 1'($urandom_range(0, 1));
         SINK_PERIODIC: rsp_tready <= (sink_tick % 7) < 2;
         default:       rsp_tready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   task automatic push_event(input logic op, input logic [CNT_W-1:0] cap,
                             input logic [CNT_W-1:0] now, input logic level);
      req_tuser  <= op;
      req_tdata  <= {7'b0, level, now, cap};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_cycles(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Hold the sender until every report is in, then let the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input logic [RELOAD_W-1:0] reload,
                                input logic [PRESC_W-1:0] presc,
                                input logic [TPU_W-1:0] tpu,
                                input logic [WORD_W-1:0] window,
                                input logic buf_en,
                                input logic [BSIZE_W-1:0] buf_size);
      csr_wr_en <= 1'b1;
      csr_index <= REG_RELOAD;   csr_wdata <= CSR_DATA_W'(reload);   @(posedge clock);
      csr_index <= REG_PRESCALE; csr_wdata <= CSR_DATA_W'(presc);    @(posedge clock);
      csr_index <= REG_TPU;      csr_wdata <= CSR_DATA_W'(tpu);      @(posedge clock);
      csr_index <= REG_WINDOW;   csr_wdata <= CSR_DATA_W'(window);   @(posedge clock);
      csr_index <= REG_BUF_EN;   csr_wdata <= CSR_DATA_W'(buf_en);   @(posedge clock);
      csr_index <= REG_BUF_SIZE; csr_wdata <= CSR_DATA_W'(buf_size); @(posedge clock);
      csr_index <= $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
      csr_wdata <= $urandom();
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_random_settings(input logic [WORD_W-1:0] window);
      logic [RELOAD_W-1:0] reload;
      logic [PRESC_W-1:0]  presc;
      logic [TPU_W-1:0]    tpu;
      logic                buf_en;
      case ($urandom_range(0, 3))
         0:       reload = '0;
         1:       reload = 1;
         2:       reload = '1;
         default: reload = RELOAD_W'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 3))
         0:       presc = 1;
         1:       presc = 65536;
         2:       presc = PRESC_W'($urandom_range(0, 131071));
         default: presc = PRESC_W'($urandom_range(1, 256));
      endcase
      case ($urandom_range(0, 3))
         0:       tpu = '0;
         1:       tpu = 1;
         2:       tpu = '1;
         default: tpu = TPU_W'($urandom_range(1, 255));
      endcase
      buf_en = 1'($urandom_range(0, 1));
      // keep the bound above any count this run can reach while it applies
      load_settings(reload, presc, tpu, window, buf_en,
                    BSIZE_W'(buf_en ? $urandom_range(4000, 65535)
                                    : $urandom_range(0, 65535)));
   endtask

   task automatic send_random(input int count, input int edge_pct, input bit gaps);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 16);
         repeat (burst) begin
            if (sent < count) begin
               push_event(($urandom_range(0, 99) < edge_pct) ? OP_EDGE : OP_OVERFLOW,
                          CNT_W'($urandom_range(0, 65535)),
                          CNT_W'($urandom_range(0, 65535)),
                          1'($urandom_range(0, 1)));
               sent++;
            end
         end
         if (gaps && $urandom_range(0, 3) != 0)
            idle_cycles(($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 5));
      end
   endtask

   initial begin
      reset      <= 1'b1;
      csr_wr_en  <= 1'b0;
      csr_index  <= REG_RELOAD;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_OVERFLOW;
      rsp_tready <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // register defaults; arm at counter zero so the default window holds
      push_event(OP_OVERFLOW, 16'hABCD, 16'h5432, 1'b1);
      push_event(OP_EDGE, 16'h1234, 16'h0000, 1'b1);
      push_event(OP_EDGE, 16'h1234, 16'h0010, 1'b0);
      push_event(OP_EDGE, 16'h1233, 16'h0020, 1'b1);
      push_event(OP_OVERFLOW, 16'h0000, 16'h0030, 1'b0);
      push_event(OP_EDGE, 16'hFFFF, 16'hFFFF, 1'b1);
      push_event(OP_OVERFLOW, 16'hFFFF, 16'h0040, 1'b0);
      push_event(OP_OVERFLOW, 16'h0000, 16'h0050, 1'b1);
      push_event(OP_EDGE, 16'h0000, 16'h0000, 1'b0);
      drain();

      load_settings(16'd1, 17'd65536, 8'd255, '1, 1'b0, 16'd0);
      push_event(OP_EDGE, 16'hFFFF, 16'hFFFF, 1'b1);
      push_event(OP_EDGE, 16'h0000, 16'h0000, 1'b0);
      push_event(OP_OVERFLOW, 16'h7FFF, 16'h8000, 1'b1);
      push_event(OP_EDGE, 16'h8000, 16'h7FFF, 1'b0);
      drain();

      // zero divisor, zero reload, widest prescale
      load_settings(16'd0, 17'h1FFFF, 8'd0, '1, 1'b1, 16'hFFFF);
      push_event(OP_OVERFLOW, 16'h0000, 16'hFFFF, 1'b0);
      push_event(OP_OVERFLOW, 16'hFFFF, 16'h0000, 1'b1);
      push_event(OP_EDGE, 16'hFFFF, 16'h1111, 1'b1);
      push_event(OP_EDGE, 16'h0001, 16'h2222, 1'b0);
      drain();

      // bridge a long run of overflows in one interval
      load_settings(16'hFFFF, 17'd1, 8'd1, '1, 1'b1, 16'hFFFF);
      push_event(OP_EDGE, 16'h4321, 16'h0100, 1'b1);
      repeat (LONG_RUN)
         push_event(OP_OVERFLOW, CNT_W'($urandom_range(0, 65535)),
                    CNT_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      push_event(OP_EDGE, 16'h4320, 16'h0200, 1'b0);
      push_event(OP_OVERFLOW, 16'h0000, 16'h0300, 1'b1);
      push_event(OP_EDGE, 16'h4322, 16'h0400, 1'b1);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         load_random_settings('1);
         send_random(PHASE_EVENTS, (p % 3 == 0) ? 20 : ((p % 3 == 1) ? 50 : 85), p != 3);
         drain();
      end

      // end the capture, by the buffer bound or the window
      if ($urandom_range(0, 1))
         load_settings(RELOAD_W'($urandom_range(1, 65535)), 17'd72, 8'd72, '1, 1'b1,
                       16'd0);
      else
         load_random_settings($urandom_range(0, 1) ? '0 : $urandom());
      send_random(60, 50, 1'b1);
      drain();

      if (mismatches == 0 && outstanding == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
